/* hw/rtl/lbr_pkg.sv */
package lbr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int STEP_BITS  = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;
  typedef logic [STEP_BITS-1:0]       steps_t;

  // opcodes of the input beat
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // per-line constants worked out from the two endpoints
  typedef struct packed {
    coord_t major_delta;
    coord_t minor_delta;
    dec_t   decision_term;
    logic   x_step_negative;
    logic   y_step_negative;
    logic   y_is_major;
  } line_setup_t;

  // walker position and progress, before or after one step
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    dec_t   decision_term;
    steps_t steps_left;
    logic   line_active;
  } walk_t;

endpackage

/* hw/rtl/lbr_in_if.sv */
interface lbr_in_if;
  import lbr_pkg::*;

  logic   valid;
  logic   ready;
  logic   opcode;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y,
    output ready
  );

endinterface

/* hw/rtl/lbr_out_if.sv */
interface lbr_out_if;
  import lbr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, last_pixel,
    output ready
  );

endinterface

/* hw/rtl/line_bresenham_rasterizer_top.sv */
// channel    dir  payload                                   beat accepted when
// line_in    in   opcode, start_x, start_y, end_x, end_y    valid && ready
// pixel_out  out  pixel_x, pixel_y, last_pixel              valid && ready
//
// one input beat per clock while input ready is high; a pixel beat leaves through the result register
// the path is one input register plus one result register around the step logic
// an advance with no line in progress is consumed and produces no pixel beat
// input ready drops only while a pixel is pending and the result register is held
// rst is synchronous, active high, and clears the valid flags and line_active
module line_bresenham_rasterizer_top (
  input logic      clk,
  input logic      rst,
  lbr_in_if.sink   line_in,
  lbr_out_if.source pixel_out
);
  import lbr_pkg::*;

  // input register
  logic   in_valid;
  logic   in_opcode;
  coord_t in_start_x;
  coord_t in_start_y;
  coord_t in_end_x;
  coord_t in_end_y;

  // line state
  line_setup_t line;
  walk_t       walk;

  // result register
  logic   out_valid;
  coord_t out_x;
  coord_t out_y;
  logic   out_last;

  line_setup_t setup_new;
  walk_t       walk_stepped;
  logic        is_start;
  logic        emits;
  logic        out_free;
  logic        fire;

  lbr_setup u_setup (
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .setup   (setup_new)
  );

  lbr_step u_step (
    .line (line),
    .cur  (walk),
    .nxt  (walk_stepped)
  );

  always_comb begin
    is_start = in_opcode == OP_START;
    // a start always produces a pixel, an advance only while a line is drawn
    emits    = is_start || walk.line_active;
    out_free = !out_valid || pixel_out.ready;
    // a beat with no pixel retires even while the output is stalled
    fire     = in_valid && (!emits || out_free);
  end

  assign line_in.ready        = !in_valid || fire;
  assign pixel_out.valid      = out_valid;
  assign pixel_out.pixel_x    = out_x;
  assign pixel_out.pixel_y    = out_y;
  assign pixel_out.last_pixel = out_last;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (line_in.ready) begin
      in_valid <= line_in.valid;
    end
    if (line_in.valid && line_in.ready) begin
      in_opcode  <= line_in.opcode;
      in_start_x <= line_in.start_x;
      in_start_y <= line_in.start_y;
      in_end_x   <= line_in.end_x;
      in_end_y   <= line_in.end_y;
    end
  end

  // line state update, one pixel per fired beat that emits one
  always_ff @(posedge clk) begin
    if (rst) begin
      walk.line_active <= 1'b0;
    end else if (fire && is_start) begin
      line                <= setup_new;
      walk.cur_x          <= in_start_x;
      walk.cur_y          <= in_start_y;
      walk.decision_term  <= setup_new.decision_term;
      walk.steps_left     <= steps_t'(setup_new.major_delta);
      walk.line_active    <= setup_new.major_delta != '0;
    end else if (fire && walk.line_active) begin
      walk <= walk_stepped;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emits) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
    if (fire && is_start) begin
      out_x    <= in_start_x;
      out_y    <= in_start_y;
      // equal endpoints give a single-pixel line
      out_last <= setup_new.major_delta == '0;
    end else if (fire && walk.line_active) begin
      out_x    <= walk_stepped.cur_x;
      out_y    <= walk_stepped.cur_y;
      out_last <= !walk_stepped.line_active;
    end
  end

endmodule

/* hw/rtl/lbr_setup.sv */
module lbr_setup (
  input  lbr_pkg::coord_t      start_x,
  input  lbr_pkg::coord_t      start_y,
  input  lbr_pkg::coord_t      end_x,
  input  lbr_pkg::coord_t      end_y,
  output lbr_pkg::line_setup_t setup
);
  import lbr_pkg::*;

  logic   x_neg;
  logic   y_neg;
  logic   y_major;
  coord_t dx;
  coord_t dy;
  coord_t major;
  coord_t minor;

  always_comb begin
    x_neg   = end_x < start_x;
    y_neg   = end_y < start_y;
    dx      = x_neg ? (start_x - end_x) : (end_x - start_x);
    dy      = y_neg ? (start_y - end_y) : (end_y - start_y);
    // a tie keeps x as the major axis
    y_major = dy > dx;
    major   = y_major ? dy : dx;
    minor   = y_major ? dx : dy;

    setup.major_delta     = major;
    setup.minor_delta     = minor;
    setup.decision_term   = dec_t'({2'b00, minor, 1'b0}) - dec_t'({3'b000, major});
    setup.x_step_negative = x_neg;
    setup.y_step_negative = y_neg;
    setup.y_is_major      = y_major;
  end

endmodule

/* hw/rtl/lbr_step.sv */
module lbr_step (
  input  lbr_pkg::line_setup_t line,
  input  lbr_pkg::walk_t       cur,
  output lbr_pkg::walk_t       nxt
);
  import lbr_pkg::*;

  dec_t   gain_major;
  dec_t   gain_both;
  coord_t x_moved;
  coord_t y_moved;
  steps_t steps_dec;

  always_comb begin
    gain_major = dec_t'({2'b00, line.minor_delta, 1'b0});
    gain_both  = gain_major - dec_t'({2'b00, line.major_delta, 1'b0});
    x_moved    = line.x_step_negative ? (cur.cur_x - coord_t'(1)) : (cur.cur_x + coord_t'(1));
    y_moved    = line.y_step_negative ? (cur.cur_y - coord_t'(1)) : (cur.cur_y + coord_t'(1));
    steps_dec  = cur.steps_left - steps_t'(1);

    nxt = cur;
    if (cur.decision_term < 0) begin
      // major axis only
      nxt.decision_term = cur.decision_term + gain_major;
      if (line.y_is_major) begin
        nxt.cur_y = y_moved;
      end else begin
        nxt.cur_x = x_moved;
      end
    end else begin
      // diagonal step
      nxt.decision_term = cur.decision_term + gain_both;
      nxt.cur_x         = x_moved;
      nxt.cur_y         = y_moved;
    end
    nxt.steps_left  = steps_dec;
    nxt.line_active = steps_dec != '0;
  end

endmodule

/* hw/rtl/lbr_checker.sv */
module lbr_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input lbr_pkg::coord_t pixel_x,
  input lbr_pkg::coord_t pixel_y,
  input logic            last_pixel
);
  import lbr_pkg::*;

  // a held pixel beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel beat dropped while stalled");

  // a held pixel beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))
    else $error("pixel payload changed while stalled");

  // reset leaves no pixel pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("pixel pending after reset");

  // input never stalls while the result register can take a pixel
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled with free result register");

  // reset leaves the input open
  a_reset_open: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input closed after reset");

endmodule

bind line_bresenham_rasterizer_top lbr_checker u_lbr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (line_in.ready),
  .out_valid  (pixel_out.valid),
  .out_ready  (pixel_out.ready),
  .pixel_x    (pixel_out.pixel_x),
  .pixel_y    (pixel_out.pixel_y),
  .last_pixel (pixel_out.last_pixel)
);

/* verif/lbr_pixel_checker.sv */
`timescale 1ns / 100ps

module lbr_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  lbr_in_if           line_in,
  lbr_out_if          pixel_out,
  output int unsigned mismatch_count,
  output int unsigned pixels_pending
);
  import lbr_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // walker state, mirrors the block
  coord_t cur_x;
  coord_t cur_y;
  coord_t major_delta;
  coord_t minor_delta;
  dec_t   decision;
  steps_t steps_left;
  logic   x_neg;
  logic   y_neg;
  logic   y_major;
  logic   line_active;

  pixel_t expected_pixels[$];

  function automatic coord_t step_coord(coord_t c, logic negative);
    return negative ? c - 1'b1 : c + 1'b1;
  endfunction

  // one input beat in, at most one pixel out
  function automatic bit rasterize_beat(logic op, coord_t sx, coord_t sy, coord_t ex,
                                        coord_t ey, output pixel_t px);
    coord_t dx;
    coord_t dy;
    if (op == OP_START) begin
      x_neg       = ex < sx;
      y_neg       = ey < sy;
      dx          = x_neg ? sx - ex : ex - sx;
      dy          = y_neg ? sy - ey : ey - sy;
      y_major     = dy > dx;   // tie keeps x as major
      major_delta = y_major ? dy : dx;
      minor_delta = y_major ? dx : dy;
      decision    = dec_t'(2 * int'(minor_delta) - int'(major_delta));
      steps_left  = steps_t'(major_delta);
      cur_x       = sx;
      cur_y       = sy;
      line_active = major_delta != 0;
    end else begin
      if (!line_active || steps_left == 0) begin
        line_active = 1'b0;
        return 1'b0;
      end
      if (decision < 0) begin
        decision = dec_t'(int'(decision) + 2 * int'(minor_delta));
        if (y_major) cur_y = step_coord(cur_y, y_neg);
        else cur_x = step_coord(cur_x, x_neg);
      end else begin
        decision = dec_t'(int'(decision) + 2 * (int'(minor_delta) - int'(major_delta)));
        cur_x = step_coord(cur_x, x_neg);
        cur_y = step_coord(cur_y, y_neg);
      end
      steps_left = steps_left - 1'b1;
      if (steps_left == 0) line_active = 1'b0;
    end
    px = '{x: cur_x, y: cur_y, last: !line_active};
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst) begin
      cur_x          = '0;
      cur_y          = '0;
      major_delta    = '0;
      minor_delta    = '0;
      decision       = '0;
      steps_left     = '0;
      x_neg          = 1'b0;
      y_neg          = 1'b0;
      y_major        = 1'b0;
      line_active    = 1'b0;
      mismatch_count = 0;
      expected_pixels.delete();
    end else begin
      if (pixel_out.valid && pixel_out.ready) begin
        got = '{x: pixel_out.pixel_x, y: pixel_out.pixel_y, last: pixel_out.last_pixel};
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected pixel: expected none, got x=%0d y=%0d last=%0b",
                   $time, got.x, got.y, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, want.x, want.y, want.last, got.x, got.y, got.last);
          end
        end
      end
      if (line_in.valid && line_in.ready) begin
        if (rasterize_beat(line_in.opcode, line_in.start_x, line_in.start_y,
                           line_in.end_x, line_in.end_y, want))
          expected_pixels.push_back(want);
      end
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

/* verif/line_bresenham_rasterizer_top_tb.sv */
`timescale 1ns / 100ps

module line_bresenham_rasterizer_top_tb;
  import lbr_pkg::*;

  localparam int     COORD_MAX = (1 << COORD_BITS) - 1;
  localparam coord_t COORD_TOP = coord_t'(COORD_MAX);

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbr_in_if  line_in ();
  lbr_out_if pixel_out ();

  int unsigned mismatch_count;
  int unsigned pixels_pending;

  // stimulus bookkeeping
  int beats_sent  = 0;
  bit source_calm = 1'b0;
  bit sink_calm   = 1'b0;
  int stall_left  = 0;

  always #2 clk = ~clk;

  line_bresenham_rasterizer_top dut (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_in),
    .pixel_out (pixel_out)
  );

  // watches both channels, predicts every pixel and compares
  lbr_pixel_checker pixel_checker (
    .clk            (clk),
    .rst            (rst),
    .line_in        (line_in),
    .pixel_out      (pixel_out),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending)
  );

  // idle length: mostly none, some short, a few long
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // any coordinate in range
  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  // coordinate within reach of c, kept inside the coordinate range
  function automatic coord_t near(coord_t c, int reach);
    int off;
    int v;
    off = $urandom_range(0, 2 * reach) - reach;
    v   = int'(c) + off;
    if (v < 0 || v > COORD_MAX) v = int'(c) - off;
    return coord_t'(v);
  endfunction

  // number of advances that walks a line to its end
  function automatic int line_length(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int dx;
    int dy;
    dx = int'(ex) - int'(sx);
    dy = int'(ey) - int'(sy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx > dy) ? dx : dy;
  endfunction

  // one input beat, preceded by a random gap unless in a calm stretch
  task automatic send_beat(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int gap;
    gap = source_calm ? 0 : gap_cycles();
    if (gap > 0) begin
      line_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line_in.valid   <= 1'b1;
    line_in.opcode  <= op;
    line_in.start_x <= sx;
    line_in.start_y <= sy;
    line_in.end_x   <= ex;
    line_in.end_y   <= ey;
    do @(posedge clk); while (!line_in.ready);
    beats_sent++;
  endtask

  // start beat, then a number of advances carrying junk endpoints
  task automatic draw_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, int advances);
    send_beat(OP_START, sx, sy, ex, ey);
    repeat (advances)
      send_beat(OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // pixel sink: random stalls, with calm stretches where ready stays high
  always @(posedge clk) begin
    int stall;
    if ($urandom_range(0, 299) == 0) sink_calm <= ~sink_calm;
    if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      pixel_out.ready <= 1'b0;
    end else begin
      stall = sink_calm ? 0 : gap_cycles();
      pixel_out.ready <= (stall == 0);
      stall_left      <= (stall > 0) ? stall - 1 : 0;
    end
  end

  initial begin
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    int     pick;
    int     walk;

    // every input known from time zero
    line_in.valid   <= 1'b0;
    line_in.opcode  <= OP_ADVANCE;
    line_in.start_x <= '0;
    line_in.start_y <= '0;
    line_in.end_x   <= '0;
    line_in.end_y   <= '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // advance before any line was started, fields at their top value
    send_beat(OP_ADVANCE, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
    // both endpoints equal: single last pixel, then an idle advance
    draw_line(coord_t'(5), coord_t'(5), coord_t'(5), coord_t'(5), 1);
    // full-range diagonals, each abandoned by the next start
    draw_line('0, '0, COORD_TOP, COORD_TOP, 1);
    draw_line(COORD_TOP, COORD_TOP, '0, '0, 1);
    draw_line(COORD_TOP, '0, '0, COORD_TOP, 1);
    // shallow line where the decision term hits zero, walked past its end
    draw_line(coord_t'(10), coord_t'(10), coord_t'(14), coord_t'(12), 5);
    // same line reversed, picks may differ on the zero term
    draw_line(coord_t'(14), coord_t'(12), coord_t'(10), coord_t'(10), 5);
    // steep line, y major and stepping down
    draw_line('0, COORD_TOP, coord_t'(2), coord_t'(COORD_MAX - 5), 5);

    while (beats_sent < 1850) begin
      if ($urandom_range(0, 49) == 0) source_calm = ~source_calm;
      sx   = rand_coord();
      sy   = rand_coord();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // short lines walked to the end, sometimes a bit past it or cut short
        ex   = near(sx, 12);
        ey   = near(sy, 12);
        walk = line_length(sx, sy, ex, ey) + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) walk = $urandom_range(0, walk);
      end else if (pick < 78) begin
        // medium lines walked fully
        ex   = near(sx, 100);
        ey   = near(sy, 100);
        walk = line_length(sx, sy, ex, ey);
      end else if (pick < 92) begin
        // arbitrary endpoints, abandoned early by the next start
        ex   = rand_coord();
        ey   = rand_coord();
        walk = $urandom_range(0, 16);
      end else begin
        // stray advance
        send_beat(OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        continue;
      end
      draw_line(sx, sy, ex, ey, walk);
    end

    line_in.valid <= 1'b0;
    @(posedge clk);
    // drain, then linger past the input and result registers to catch strays
    while (pixels_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lbr_pkg.sv
hw/rtl/lbr_in_if.sv
hw/rtl/lbr_out_if.sv
hw/rtl/lbr_setup.sv
hw/rtl/lbr_step.sv
hw/rtl/line_bresenham_rasterizer_top.sv
hw/rtl/lbr_checker.sv
verif/lbr_pixel_checker.sv
verif/line_bresenham_rasterizer_top_tb.sv
